/* sv/dbas_pkg.sv */
// ----------------------------------------------------------------------------
// dbas_pkg
// Types and constants shared by the double-beep alarm sequencer.
// ----------------------------------------------------------------------------
package dbas_pkg;

	localparam int unsigned DUR_W     = 16;
	localparam int unsigned ELAPSED_W = DUR_W + 1;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DUR_W-1:0] TONE_MS_RST        = DUR_W'(100);
	localparam logic [DUR_W-1:0] SHORT_PAUSE_MS_RST = DUR_W'(100);
	localparam logic [DUR_W-1:0] LONG_PAUSE_MS_RST  = DUR_W'(500);

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE_MS        = 2'd0,
		REG_SHORT_PAUSE_MS = 2'd1,
		REG_LONG_PAUSE_MS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_OFF    = 3'd0,
		PH_TONE1  = 3'd1,
		PH_PAUSE1 = 3'd2,
		PH_TONE2  = 3'd3,
		PH_PAUSE2 = 3'd4
	} phase_t;

endpackage

/* sv/double_beep_alarm_sequencer.sv */
// ----------------------------------------------------------------------------
// double_beep_alarm_sequencer
// Buzzer pattern sequencer: tone, short pause, tone, long pause, repeated.
// ----------------------------------------------------------------------------
// Each accepted item (tick, start, stop or unused code) yields exactly one
// result item that shows the pin level and phase after the update. Items pass
// through one input register and update the sequencer state, which doubles as
// the result register; one item is taken per cycle while the result side does
// not stall. Configuration writes take effect at once and are meant to happen
// while no item is in flight.
module double_beep_alarm_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [dbas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbas_pkg::DUR_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [dbas_pkg::COUNT_W-1:0]        repeat_limit,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                pin_level,
	output logic [2:0]                          phase
);

	logic [dbas_pkg::DUR_W-1:0] tone_ms_q, short_pause_ms_q, long_pause_ms_q;

	logic                          valid_s1;
	dbas_pkg::cmd_t                cmd_s1;
	logic [dbas_pkg::COUNT_W-1:0]  limit_s1;

	logic                          out_valid_q;
	dbas_pkg::phase_t              phase_q, phase_d;
	logic [dbas_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [dbas_pkg::COUNT_W-1:0]  done_q, done_d, wanted_q, wanted_d;
	logic                          drive_q, drive_d;
	logic [dbas_pkg::DUR_W-1:0]    dur_sel;
	logic [dbas_pkg::COUNT_W:0]    count_next;
	logic                          advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_ms_q        <= dbas_pkg::TONE_MS_RST;
			short_pause_ms_q <= dbas_pkg::SHORT_PAUSE_MS_RST;
			long_pause_ms_q  <= dbas_pkg::LONG_PAUSE_MS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dbas_pkg::REG_TONE_MS:        tone_ms_q        <= cfg_data;
				dbas_pkg::REG_SHORT_PAUSE_MS: short_pause_ms_q <= cfg_data;
				dbas_pkg::REG_LONG_PAUSE_MS:  long_pause_ms_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= dbas_pkg::cmd_t'(cmd);
			limit_s1 <= repeat_limit;
		end
	end

	// sequencer state; also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= dbas_pkg::PH_OFF;
			elapsed_q   <= '0;
			done_q      <= '0;
			wanted_q    <= '0;
			drive_q     <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q   <= phase_d;
				elapsed_q <= elapsed_d;
				done_q    <= done_d;
				wanted_q  <= wanted_d;
				drive_q   <= drive_d;
			end
		end
	end

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign count_next  = {1'b0, done_q} + 1'b1;

	always_comb begin
		unique case (phase_q)
			dbas_pkg::PH_PAUSE1: dur_sel = short_pause_ms_q;
			dbas_pkg::PH_PAUSE2: dur_sel = long_pause_ms_q;
			default:             dur_sel = tone_ms_q;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		done_d    = done_q;
		wanted_d  = wanted_q;
		drive_d   = drive_q;
		unique case (cmd_s1)
			dbas_pkg::CMD_START: begin
				wanted_d  = limit_s1;
				done_d    = '0;
				phase_d   = dbas_pkg::PH_TONE1;
				elapsed_d = '0;
				drive_d   = 1'b1;
			end
			dbas_pkg::CMD_STOP: begin
				phase_d = dbas_pkg::PH_OFF;
				done_d  = '0;
				drive_d = 1'b0;
			end
			dbas_pkg::CMD_TICK: begin
				if (phase_q != dbas_pkg::PH_OFF) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > {1'b0, dur_sel}) begin
						elapsed_d = '0;
						unique case (phase_q)
							dbas_pkg::PH_TONE1: begin
								phase_d = dbas_pkg::PH_PAUSE1;
								drive_d = 1'b0;
							end
							dbas_pkg::PH_PAUSE1: begin
								phase_d = dbas_pkg::PH_TONE2;
								drive_d = 1'b1;
							end
							dbas_pkg::PH_TONE2: begin
								phase_d = dbas_pkg::PH_PAUSE2;
								drive_d = 1'b0;
							end
							default: begin
								if (count_next >= {1'b0, wanted_q}) begin
									phase_d   = dbas_pkg::PH_OFF;
									done_d    = '0;
									drive_d   = 1'b0;
									elapsed_d = elapsed_inc;
								end else begin
									done_d  = count_next[dbas_pkg::COUNT_W-1:0];
									phase_d = dbas_pkg::PH_TONE1;
									drive_d = 1'b1;
								end
							end
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign pin_level = drive_q;
	assign phase     = phase_q;

	a_off_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dbas_pkg::PH_OFF) |-> !drive_q)
		else $error("pin high while sequence off");

	a_tone_pin_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dbas_pkg::PH_TONE1 || phase_q == dbas_pkg::PH_TONE2) |-> drive_q)
		else $error("pin low during a tone");

	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == dbas_pkg::CMD_STOP) |=>
		(phase_q == dbas_pkg::PH_OFF && done_q == '0))
		else $error("stop did not end the sequence");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

endmodule

/* dv/double_beep_alarm_sequencer_test.sv */
// ----------------------------------------------------------------------------
// double_beep_alarm_sequencer_test
// Self-checking bench for the double-beep buzzer sequencer.
// ----------------------------------------------------------------------------
// Items are driven over the valid/stall input channel and every result item is
// compared with a cycle-free model of the tone/pause/tone/pause pattern kept
// in a small scoreboard class. The run starts with directed items: start,
// stop, restart, unused command and ticks while off. It then plays a long
// tone into the short pause and the second tone and ends with randomized
// phases under several duration settings. Random idling on both channels
// and one long receiver hold-off are included.
// ----------------------------------------------------------------------------
module double_beep_alarm_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]                     CMD_UNUSED         = 2'd3;
	localparam logic [dbas_pkg::CFG_IDX_W-1:0] REG_UNUSED         = 2'd3;
	localparam int                             QUIET_LIMIT        = 5000;
	localparam int                             HOLD_CYCLES        = 300;
	localparam int                             DRAIN_CYCLES       = 8;
	localparam int                             RANDOM_PHASE_ITEMS = 90;
	localparam int                             MAX_REPORTS        = 10;

	typedef struct packed {
		logic             pin;
		dbas_pkg::phase_t ph;
	} buzzer_out_t;

	class beep_scoreboard;
		logic [dbas_pkg::DUR_W-1:0]     tone_ms;
		logic [dbas_pkg::DUR_W-1:0]     short_pause_ms;
		logic [dbas_pkg::DUR_W-1:0]     long_pause_ms;
		dbas_pkg::phase_t               cur_phase;
		logic [dbas_pkg::ELAPSED_W-1:0] elapsed;
		logic [dbas_pkg::COUNT_W-1:0]   patterns_played;
		logic [dbas_pkg::COUNT_W-1:0]   patterns_wanted;
		logic                           level;
		buzzer_out_t                    expected_q[$];
		int                             mismatches;
		int                             results_seen;
		int                             items_taken;
		int                             sequences_finished;
		int                             restarts;

		function new();
			tone_ms = dbas_pkg::TONE_MS_RST;
			short_pause_ms = dbas_pkg::SHORT_PAUSE_MS_RST;
			long_pause_ms = dbas_pkg::LONG_PAUSE_MS_RST;
			cur_phase = dbas_pkg::PH_OFF;
			elapsed = '0;
			patterns_played = '0;
			patterns_wanted = '0;
			level = 1'b0;
		endfunction

		function void write_reg(logic [dbas_pkg::CFG_IDX_W-1:0] idx,
				logic [dbas_pkg::DUR_W-1:0] data);
			case (idx)
				dbas_pkg::REG_TONE_MS:        tone_ms = data;
				dbas_pkg::REG_SHORT_PAUSE_MS: short_pause_ms = data;
				dbas_pkg::REG_LONG_PAUSE_MS:  long_pause_ms = data;
				default: ;
			endcase
		endfunction

		function bit is_running();
			return cur_phase != dbas_pkg::PH_OFF;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void enter_phase(dbas_pkg::phase_t nxt, logic lvl);
			cur_phase = nxt;
			elapsed = '0;
			level = lvl;
		endfunction

		function void halt();
			cur_phase = dbas_pkg::PH_OFF;
			patterns_played = '0;
			level = 1'b0;
		endfunction

		// one millisecond tick
		function void advance_ms();
			logic [dbas_pkg::DUR_W-1:0] dur;
			int unsigned                count;
			if (cur_phase == dbas_pkg::PH_OFF)
				return;
			if (elapsed != '1)
				elapsed++;
			case (cur_phase)
				dbas_pkg::PH_PAUSE1: dur = short_pause_ms;
				dbas_pkg::PH_PAUSE2: dur = long_pause_ms;
				default:             dur = tone_ms;
			endcase
			if (elapsed <= {1'b0, dur})
				return;
			case (cur_phase)
				dbas_pkg::PH_TONE1:  enter_phase(dbas_pkg::PH_PAUSE1, 1'b0);
				dbas_pkg::PH_PAUSE1: enter_phase(dbas_pkg::PH_TONE2, 1'b1);
				dbas_pkg::PH_TONE2:  enter_phase(dbas_pkg::PH_PAUSE2, 1'b0);
				default: begin
					count = patterns_played + 1;
					if (count >= patterns_wanted) begin
						halt();
						sequences_finished++;
					end else begin
						patterns_played = count[dbas_pkg::COUNT_W-1:0];
						enter_phase(dbas_pkg::PH_TONE1, 1'b1);
					end
				end
			endcase
		endfunction

		function void note_input(logic [1:0] c, logic [dbas_pkg::COUNT_W-1:0] lim);
			items_taken++;
			case (c)
				dbas_pkg::CMD_TICK: advance_ms();
				dbas_pkg::CMD_START: begin
					if (cur_phase != dbas_pkg::PH_OFF)
						restarts++;
					patterns_wanted = lim;
					patterns_played = '0;
					enter_phase(dbas_pkg::PH_TONE1, 1'b1);
				end
				dbas_pkg::CMD_STOP: halt();
				default: ;
			endcase
			expected_q.push_back(buzzer_out_t'{pin: level, ph: cur_phase});
		endfunction

		function void check_result(logic got_pin, logic [2:0] got_ph);
			buzzer_out_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result item with none expected: pin=%0b phase=%0d",
						$realtime, got_pin, got_ph);
				return;
			end
			want = expected_q.pop_front();
			if (got_pin !== want.pin || got_ph !== want.ph) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: mismatch on result %0d: expected pin=%0b phase=%0d,",
						" got pin=%0b phase=%0d"},
						$realtime, results_seen, want.pin, want.ph, got_pin, got_ph);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [dbas_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dbas_pkg::DUR_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [1:0]                     cmd;
	logic [dbas_pkg::COUNT_W-1:0]   repeat_limit;
	logic                           out_valid;
	logic                           out_stall;
	logic                           pin_level;
	logic [2:0]                     phase;

	beep_scoreboard board;
	bit             tx_idle_en;
	bit             rx_idle_en;
	bit             hold_request;
	int             quiet_cycles = 0;

	double_beep_alarm_sequencer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.repeat_limit (repeat_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pin_level    (pin_level),
		.phase        (phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(pin_level, phase);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, giving up", $realtime, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic [1:0] c, logic [dbas_pkg::COUNT_W-1:0] lim);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		repeat_limit <= lim;
		do
			@(posedge clk);
		while (in_stall);
		board.note_input(c, lim);
	endtask

	task automatic write_reg(logic [dbas_pkg::CFG_IDX_W-1:0] idx,
			logic [dbas_pkg::DUR_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic configure(logic [dbas_pkg::DUR_W-1:0] t, logic [dbas_pkg::DUR_W-1:0] s,
			logic [dbas_pkg::DUR_W-1:0] l);
		write_reg(dbas_pkg::REG_TONE_MS, t);
		write_reg(dbas_pkg::REG_SHORT_PAUSE_MS, s);
		write_reg(dbas_pkg::REG_LONG_PAUSE_MS, l);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [dbas_pkg::DUR_W-1:0] short_ms();
		return dbas_pkg::DUR_W'($urandom_range(0, 4));
	endfunction

	// mostly started sequences with ticks; stop, restart and unused codes as noise
	task automatic run_random(int n_items, bit with_hold);
		int                           counted;
		int                           pick;
		bit                           hold_sent;
		bit                           effective;
		logic [1:0]                   c;
		logic [dbas_pkg::COUNT_W-1:0] lim;
		counted = 0;
		hold_sent = 1'b0;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 3) != 0)
				lim = dbas_pkg::COUNT_W'($urandom_range(0, 4));
			else
				lim = dbas_pkg::COUNT_W'($urandom);
			if (!board.is_running())
				c = (pick < 55) ? dbas_pkg::CMD_START : (pick < 75) ? dbas_pkg::CMD_TICK :
					(pick < 88) ? dbas_pkg::CMD_STOP : CMD_UNUSED;
			else
				c = (pick < 84) ? dbas_pkg::CMD_TICK : (pick < 91) ? dbas_pkg::CMD_START :
					(pick < 95) ? dbas_pkg::CMD_STOP : CMD_UNUSED;
			effective = (c == dbas_pkg::CMD_START) || (board.is_running() && c != CMD_UNUSED);
			if (with_hold && !hold_sent && counted >= n_items / 3) begin
				hold_request = 1'b1;
				hold_sent = 1'b1;
			end
			send_item(c, lim);
			if (effective)
				counted++;
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = dbas_pkg::CMD_TICK;
		repeat_limit = '0;
		cfg_wr_en = 1'b0;
		cfg_index = dbas_pkg::REG_TONE_MS;
		cfg_data = '0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset durations: tick while off, unused code, start, restart, stop
		send_item(dbas_pkg::CMD_TICK, 8'hFF);
		send_item(CMD_UNUSED, 8'hFF);
		send_item(dbas_pkg::CMD_START, 8'hFF);
		send_item(dbas_pkg::CMD_TICK, 8'h00);
		send_item(dbas_pkg::CMD_START, 8'h00);
		send_item(dbas_pkg::CMD_STOP, 8'hFF);
		send_item(dbas_pkg::CMD_TICK, 8'h00);
		wait_idle();

		// zero durations: every tick ends a phase
		configure('0, '0, '0);
		send_item(dbas_pkg::CMD_START, 8'd1);
		repeat (5) send_item(dbas_pkg::CMD_TICK, 8'h00);
		send_item(dbas_pkg::CMD_START, 8'd2);
		repeat (8) send_item(dbas_pkg::CMD_TICK, dbas_pkg::COUNT_W'($urandom));
		wait_idle();

		// long tone runs out into the short pause and the second tone
		write_reg(REG_UNUSED, 16'hFFFF);
		configure(dbas_pkg::DUR_W'(40), '0, '1);
		send_item(dbas_pkg::CMD_START, 8'd1);
		repeat (42) send_item(dbas_pkg::CMD_TICK, 8'h00);
		send_item(dbas_pkg::CMD_STOP, 8'h00);
		wait_idle();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		configure(short_ms(), short_ms(), short_ms());
		run_random(RANDOM_PHASE_ITEMS, 1'b1);
		wait_idle();

		configure(short_ms(), short_ms(), dbas_pkg::DUR_W'($urandom_range(10, 40)));
		run_random(RANDOM_PHASE_ITEMS, 1'b0);
		wait_idle();

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		configure(short_ms(), short_ms(), short_ms());
		run_random(RANDOM_PHASE_ITEMS, 1'b0);
		wait_idle();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		configure(dbas_pkg::DUR_W'(1), '0, dbas_pkg::DUR_W'(3));
		run_random(RANDOM_PHASE_ITEMS, 1'b0);
		wait_idle();

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		configure(short_ms(), short_ms(), short_ms());
		run_random(RANDOM_PHASE_ITEMS, 1'b0);
		wait_idle();

		$display("Covered %0d items and %0d results over eight duration settings;",
			board.items_taken, board.results_seen);
		$display({"%0d sequences ran out their repeat limit, %0d restarts while sounding,",
			" %0d mismatches."},
			board.sequences_finished, board.restarts, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
